// ===== src/fwts_pkg.sv =====
// shared types and constants for the five-way tree key search block
// no dependencies

package fwts_pkg;

    localparam int KEY_W           = 32;
    localparam int IDX_W           = 12;
    localparam int CNT_W           = 13;
    localparam int SLOTS           = 4;
    localparam int LANE_W          = 2;
    localparam int DEF_STORE_WORDS = 4096;

    // request type codes
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef key_t [SLOTS-1:0] key_row_t;

    // write control toward the key store
    typedef struct packed {
        logic              en;
        logic [LANE_W-1:0] lane;
    } wr_ctl_t;

endpackage

// ===== src/fwts_key_store.sv =====
// key store: four banks with a separate write row and read row each, one key lane each, one block per row
// depends on fwts_pkg

module fwts_key_store
    import fwts_pkg::*;
#(
    parameter int ROWS  = DEF_STORE_WORDS / SLOTS,
    parameter int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic             aclk,
    input  wr_ctl_t          wr_ctl,
    input  logic [ROW_W-1:0] wr_row,
    input  key_t             wr_data,
    input  logic [ROW_W-1:0] rd_row,
    output key_row_t         rd_data
);

    for (genvar l = 0; l < SLOTS; l++) begin : g_bank
        key_t bank_mem [ROWS];

        always_ff @(posedge aclk) begin
            if (wr_ctl.en && (wr_ctl.lane == LANE_W'(l))) begin
                bank_mem[wr_row] <= wr_data;
            end
            rd_data[l] <= bank_mem[rd_row];
        end
    end

endmodule

// ===== src/five_way_tree_key_search.sv =====
// top level of the five-way tree key search block
// depends on fwts_pkg and fwts_key_store
//
// channel   direction  ports                                        beat
// s_        in         s_valid/s_ready, s_req_type, s_word_index,   write or search request
//                      s_key_value
// m_        out        m_valid/m_ready, m_found                     one per search
// cfg_      in         cfg_valid/cfg_ready, cfg_key_count           key count register
//
// a write beat is taken in the idle state; a search beat starts a walk that visits one tree
// level per walk step (at most 6 levels for 4096 keys); a walk over an empty tree ends at its first step
// each walk step is the loop registered row read -> four signed compares -> next block row
// reset (aresetn low, synchronous) clears control and the key count, not the store
// a search that finishes while m_ holds an untaken beat waits in place on that row

module five_way_tree_key_search
    import fwts_pkg::*;
#(
    parameter int STORE_WORDS = DEF_STORE_WORDS
) (
    input  logic             aclk,
    input  logic             aresetn,
    // request channel
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_req_type,
    input  logic [IDX_W-1:0] s_word_index,
    input  key_t             s_key_value,
    // result channel
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_found,
    // key count register
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_key_count
);

    localparam int ROWS  = (STORE_WORDS + SLOTS - 1) / SLOTS;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    // block index can reach 5 * ROWS before the walk stops
    localparam int BLK_W = $clog2(5 * ROWS + 1);
    localparam int VAL_W = $clog2(STORE_WORDS + 1);

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   key_count_reg;
    logic [BLK_W-1:0]   blk_reg;
    logic [BLK_W-1:0]   blk_next;
    key_t               key_reg;
    logic               m_valid_reg;
    logic               m_found_reg;

    logic [VAL_W-1:0]   valid_cnt;
    logic [BLK_W-1:0]   blocks;
    logic               s_fire;
    logic               live;
    logic [SLOTS-1:0]   slot_ok;
    logic [SLOTS-1:0]   slot_eq;
    logic [SLOTS-1:0]   slot_lt;
    logic               hit;
    logic [2:0]         below;
    logic               go_on;
    logic               finish;
    logic               out_free;

    wr_ctl_t            wr_ctl;
    logic [31:0]        wr_word32;
    logic [ROW_W-1:0]   wr_row;
    logic [ROW_W-1:0]   rd_row;
    key_row_t           rd_data;

    // ------------------------------------------------------------------
    // configuration: key count, clamped to the store size
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_count_reg <= '0;
        end else if (cfg_valid) begin
            key_count_reg <= cfg_key_count;
        end
    end

    assign valid_cnt = (32'(key_count_reg) > 32'(STORE_WORDS)) ?
                       VAL_W'(STORE_WORDS) : VAL_W'(key_count_reg);
    // number of four-key blocks that hold valid keys
    assign blocks    = BLK_W'((32'(valid_cnt) + 32'd3) >> 2);

    // ------------------------------------------------------------------
    // request side: writes go straight into the store, searches start a walk
    // ------------------------------------------------------------------
    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    assign wr_word32   = 32'(s_word_index);
    assign wr_row      = wr_word32[ROW_W+1:2];
    assign wr_ctl.en   = s_fire && (s_req_type == REQ_WRITE)
                         && (wr_word32 < 32'(STORE_WORDS));
    assign wr_ctl.lane = s_word_index[LANE_W-1:0];

    fwts_key_store #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_store (
        .aclk    (aclk),
        .wr_ctl  (wr_ctl),
        .wr_row  (wr_row),
        .wr_data (s_key_value),
        .rd_row  (rd_row),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // walk datapath: rd_data holds the row of blk_reg in every walk cycle
    // ------------------------------------------------------------------
    always_comb begin
        for (int s = 0; s < SLOTS; s++) begin
            // slots at or past the key count neither match nor count
            slot_ok[s] = ((32'(blk_reg) << 2) + 32'(s)) < 32'(valid_cnt);
            slot_eq[s] = slot_ok[s] && (rd_data[s] == key_reg);
            slot_lt[s] = slot_ok[s] && ($signed(rd_data[s]) < key_reg);
        end
    end

    assign live     = (blk_reg < blocks);
    assign hit      = live && (|slot_eq);
    assign below    = 3'($countones(slot_lt));
    // child 5b + 1 + below
    assign blk_next = BLK_W'((32'(blk_reg) * 32'd5) + 32'd1 + 32'(below));
    assign go_on    = live && !hit && (blk_next < blocks);
    assign finish   = (state_reg == ST_WALK) && !go_on;
    assign out_free = !m_valid_reg || m_ready;

    // read address: block 0 while idle so a new search has its root next cycle,
    // the child block while walking, the same block while a result waits
    always_comb begin
        case (state_reg)
            ST_IDLE: rd_row = '0;
            ST_WALK: rd_row = go_on ? blk_next[ROW_W-1:0] : blk_reg[ROW_W-1:0];
            default: rd_row = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // control and result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // a finishing walk loads the result beat, otherwise a taken beat empties it
            if (finish && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire && (s_req_type == REQ_SEARCH)) begin
                        state_reg <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (finish && out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire && (s_req_type == REQ_SEARCH)) begin
            key_reg <= s_key_value;
            blk_reg <= '0;
        end else if ((state_reg == ST_WALK) && go_on) begin
            blk_reg <= blk_next;
        end
        if (finish && out_free) begin
            m_found_reg <= hit;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_found = m_found_reg;

`ifndef SYNTH
    // a search always starts at the root block
    a_search_starts_at_root: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_req_type == REQ_SEARCH))
        |=> ((state_reg == ST_WALK) && (blk_reg == '0)))
        else $error("search did not start at block 0");

    // a new result only comes out of a finishing walk
    a_result_from_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past((state_reg == ST_WALK) && finish))
        else $error("result raised without a finished walk");

    // a finished walk blocked by the output holds its block
    a_stall_holds_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (finish && m_valid_reg && !m_ready)
        |=> ((state_reg == ST_WALK) && $stable(blk_reg)))
        else $error("stalled walk lost its block");

    // a walk only continues inside the valid blocks
    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_WALK) && go_on) |=> (blk_reg < blocks))
        else $error("walk stepped past the last block");
`endif

endmodule
